// File: rtl/core/wtml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtml_pkg
// Shared types, constants and character helpers for the word tokenizer.
// ----------------------------------------------------------------------------
package wtml_pkg;

	localparam int WORD_BUFFER_BYTES_DEF = 32;

	localparam int MIN_LEN_W = 6;
	localparam int LIMIT_W   = 16;
	localparam int CHAR_W    = 8;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd5;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 16'hFFFF;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_LEN    = 1'b0;
	localparam logic REG_WORD_LIMIT = 1'b1;

	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic [MIN_LEN_W-1:0] min_len;
		logic [LIMIT_W-1:0]   limit;
	} cfg_t;

	function automatic logic is_upper(input logic [CHAR_W-1:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39));
	endfunction

	function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
		return is_upper(c) ? (c + CASE_OFFSET) : c;
	endfunction

endpackage

// File: rtl/core/wtml_word_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtml_word_buf
// Single write, single read character store with registered read data.
// ----------------------------------------------------------------------------
module wtml_word_buf #(
	parameter int DEPTH = 31,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [wtml_pkg::CHAR_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [wtml_pkg::CHAR_W-1:0] rd_data
);
	import wtml_pkg::*;

	logic [CHAR_W-1:0] mem_q [DEPTH];
	logic [CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/wtml_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtml_seq
// Word collection and replay sequencer with output register.
// ----------------------------------------------------------------------------
module wtml_seq #(
	parameter int WORD_BUFFER_BYTES = wtml_pkg::WORD_BUFFER_BYTES_DEF,
	parameter int AW = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wtml_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [wtml_pkg::CHAR_W-1:0]  text_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wtml_pkg::CHAR_W-1:0]  word_char,
	output logic                         word_end,
	output logic [wtml_pkg::LIMIT_W-1:0] word_number,
	output logic                         mem_wr_en,
	output logic [AW-1:0]                mem_wr_addr,
	output logic [wtml_pkg::CHAR_W-1:0]  mem_wr_data,
	output logic                         mem_rd_en,
	output logic [AW-1:0]                mem_rd_addr,
	input  logic [wtml_pkg::CHAR_W-1:0]  mem_rd_data
);
	import wtml_pkg::*;

	localparam int CAP  = WORD_BUFFER_BYTES - 1;
	localparam int LW   = $clog2(WORD_BUFFER_BYTES);
	localparam int CMPW = 7;
	localparam logic [LW-1:0] CAP_LEN = LW'(CAP);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SHOW
	} state_t;

	state_t            state_q;
	logic [LW-1:0]     len_q;
	logic [LIMIT_W-1:0] count_q;
	logic [LIMIT_W-1:0] num_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     last_idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              end_q;
	logic [LIMIT_W-1:0] number_q;

	logic accept;
	logic alnum;
	logic room;
	logic emit;
	logic out_free;
	logic last;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign alnum    = is_alnum(text_byte);
	assign room     = (len_q < CAP_LEN);
	assign emit     = (len_q != '0) && (CMPW'(len_q) >= CMPW'(cfg.min_len)) &&
	                  (count_q < cfg.limit);
	assign out_free = !out_valid_q || !out_stall;
	assign last     = (rd_idx_q == last_idx_q);

	assign mem_wr_en   = accept && alnum && room;
	assign mem_wr_addr = len_q[AW-1:0];
	assign mem_wr_data = to_lower(text_byte);
	assign mem_rd_en   = (state_q == ST_FETCH);
	assign mem_rd_addr = rd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			count_q     <= '0;
			num_q       <= '0;
			rd_idx_q    <= '0;
			last_idx_q  <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			end_q       <= 1'b0;
			number_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_SHOW)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (alnum) begin
							if (room) begin
								len_q <= len_q + 1'b1;
							end
						end else begin
							len_q <= '0;
							if (emit) begin
								num_q      <= count_q;
								count_q    <= count_q + 1'b1;
								rd_idx_q   <= '0;
								last_idx_q <= AW'(len_q - 1'b1);
								state_q    <= ST_FETCH;
							end
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						char_q      <= mem_rd_data;
						end_q       <= last;
						number_q    <= num_q;
						rd_idx_q    <= rd_idx_q + 1'b1;
						state_q     <= last ? ST_IDLE : ST_FETCH;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign word_char   = char_q;
	assign word_end    = end_q;
	assign word_number = number_q;

endmodule

// File: rtl/core/word_tokenizer_min_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_min_length
// Alphanumeric word tokenizer with minimum word length and word limit.
// ----------------------------------------------------------------------------
// Input channel: one text byte per request (in_valid / in_stall). Letters
// and digits are lower-cased and stored; any other byte ends the word.
// A character request, or a separator that emits nothing, is taken without
// raising in_stall.
// A separator that emits a word of n characters holds in_stall high while
// the word is replayed: each character is first read from the word store
// (fetch step) and then loaded into the output register (load step).
// Output channel: one character per request (out_valid / out_stall), with
// word_end on the last character and word_number counting from zero.
// While out_stall is high with out_valid set, the output register holds
// and the sequencer waits in its load step.
// Reset clears the word length, the word count and the output valid, and
// sets min_word_length to 5 and word_limit to 65535. No clearing pass is
// needed. Configuration goes over the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module word_tokenizer_min_length #(
	parameter int WORD_BUFFER_BYTES = wtml_pkg::WORD_BUFFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wtml_pkg::PADDR_W-1:0]  paddr,
	input  logic [wtml_pkg::PDATA_W-1:0]  pwdata,
	output logic [wtml_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wtml_pkg::CHAR_W-1:0]   text_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wtml_pkg::CHAR_W-1:0]   word_char,
	output logic                          word_end,
	output logic [wtml_pkg::LIMIT_W-1:0]  word_number
);
	import wtml_pkg::*;

	localparam int CAP = WORD_BUFFER_BYTES - 1;
	localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

	logic [MIN_LEN_W-1:0] min_len_q;
	logic [LIMIT_W-1:0]   limit_q;
	cfg_t                 cfg;
	logic                 cfg_wr;
	logic                 reg_sel;
	logic                 aligned;

	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [CHAR_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	logic [CHAR_W-1:0] mem_rd_data;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign aligned = (paddr[1:0] == 2'b00);
	assign cfg_wr  = psel && penable && pwrite && pready && aligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MIN_LEN:    min_len_q <= pwdata[MIN_LEN_W-1:0];
				REG_WORD_LIMIT: limit_q   <= pwdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (aligned) begin
			unique case (reg_sel)
				REG_MIN_LEN:    prdata = PDATA_W'(min_len_q);
				REG_WORD_LIMIT: prdata = PDATA_W'(limit_q);
				default:        prdata = '0;
			endcase
		end
	end

	assign cfg.min_len = min_len_q;
	assign cfg.limit   = limit_q;

	wtml_word_buf #(
		.DEPTH (CAP),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	wtml_seq #(
		.WORD_BUFFER_BYTES (WORD_BUFFER_BYTES),
		.AW                (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word_char   (word_char),
		.word_end    (word_end),
		.word_number (word_number),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

endmodule

// File: dv/wtml_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtml_checker
// Watches the register port and both request channels of the word tokenizer,
// predicts the character stream of every ended word and compares each output
// request, field by field, with the oldest predicted character.
// ----------------------------------------------------------------------------
module wtml_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wtml_pkg::PADDR_W-1:0]  paddr,
	input  logic [wtml_pkg::PDATA_W-1:0]  pwdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [wtml_pkg::CHAR_W-1:0]   text_byte,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [wtml_pkg::CHAR_W-1:0]   word_char,
	input  logic                          word_end,
	input  logic [wtml_pkg::LIMIT_W-1:0]  word_number,
	output int                            mismatches,
	output int                            pending
);

	localparam int WORD_CAPACITY = wtml_pkg::WORD_BUFFER_BYTES_DEF - 1;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [wtml_pkg::CHAR_W-1:0]  ch;
		logic                         last;
		logic [wtml_pkg::LIMIT_W-1:0] idx;
	} word_char_t;

	word_char_t                   expected_chars[$];
	wtml_pkg::cfg_t               cfg;
	logic [wtml_pkg::CHAR_W-1:0]  word_buf [0:WORD_CAPACITY-1];
	logic [4:0]                   fill_len;
	logic [wtml_pkg::LIMIT_W-1:0] words_emitted;

	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	task automatic tokenize_byte(input logic [7:0] c);
		word_char_t wc;
		if (is_word_byte(c)) begin
			if (fill_len < WORD_CAPACITY) begin
				word_buf[fill_len] = fold_case(c);
				fill_len = fill_len + 5'd1;
			end
		end else begin
			if (fill_len != 0 && {1'b0, fill_len} >= cfg.min_len &&
					words_emitted < cfg.limit) begin
				for (int k = 0; k < fill_len; k++) begin
					wc.ch   = word_buf[k];
					wc.last = (k == fill_len - 1);
					wc.idx  = words_emitted;
					expected_chars.push_back(wc);
				end
				words_emitted = words_emitted + 16'd1;
			end
			fill_len = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			cfg.min_len   = wtml_pkg::MIN_LEN_RESET;
			cfg.limit     = wtml_pkg::LIMIT_RESET;
			fill_len      = '0;
			words_emitted = '0;
			mismatches    = 0;
			pending       = 0;
		end else begin
			// compare before predicting: a result never leaves in its request's cycle
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected result: char %h end %b number %0d",
							word_char, word_end, word_number);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (word_char !== want.ch || word_end !== want.last ||
							word_number !== want.idx) begin
						if (mismatches < REPORT_LIMIT)
							$display({"mismatch: exp char %h end %b number %0d, ",
								"got char %h end %b number %0d"},
								want.ch, want.last, want.idx,
								word_char, word_end, word_number);
						mismatches++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == wtml_pkg::REG_MIN_LEN)
					cfg.min_len = pwdata[wtml_pkg::MIN_LEN_W-1:0];
				else
					cfg.limit = pwdata[wtml_pkg::LIMIT_W-1:0];
			end
			if (in_valid && !in_stall)
				tokenize_byte(text_byte);
			pending = expected_chars.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the word tokenizer: a short directed text, then
// random words, noise and long truncated words under several register
// settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [wtml_pkg::PADDR_W-1:0] ADDR_MIN_LEN    = 3'd0;
	localparam logic [wtml_pkg::PADDR_W-1:0] ADDR_WORD_LIMIT = 3'd4;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 3000;
	localparam int DIRECTED_LEN  = 24;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [wtml_pkg::PADDR_W-1:0]  paddr;
	logic [wtml_pkg::PDATA_W-1:0]  pwdata;
	logic [wtml_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic [wtml_pkg::CHAR_W-1:0]   text_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [wtml_pkg::CHAR_W-1:0]   word_char;
	logic                          word_end;
	logic [wtml_pkg::LIMIT_W-1:0]  word_number;

	int mismatches;
	int pending;
	int in_idle_pct;
	int out_idle_pct;
	int quiet_cycles = 0;

	// boundary letters and digits, separator range edges but 0x01 and 0x7F, empty words
	logic [7:0] directed_text [0:DIRECTED_LEN-1] = '{
		8'h41, 8'h7A, 8'h30, 8'h39, 8'h5A, 8'h00,
		8'h61, 8'h5A, 8'h39, 8'h30, 8'hFF,
		8'h2F,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h3A,
		8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	word_tokenizer_min_length u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word_char   (word_char),
		.word_end    (word_end),
		.word_number (word_number)
	);

	wtml_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word_char   (word_char),
		.word_end    (word_end),
		.word_number (word_number),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_word_byte();
		case ($urandom_range(2))
			0:       return 8'($urandom_range(8'h39, 8'h30));
			1:       return 8'($urandom_range(8'h5A, 8'h41));
			default: return 8'($urandom_range(8'h7A, 8'h61));
		endcase
	endfunction

	function automatic logic [7:0] rand_separator();
		case ($urandom_range(5))
			0:       return 8'h00;
			1:       return 8'($urandom_range(8'h2F, 8'h01));
			2:       return 8'($urandom_range(8'h40, 8'h3A));
			3:       return 8'($urandom_range(8'h60, 8'h5B));
			4:       return 8'($urandom_range(8'h7F, 8'h7B));
			default: return 8'($urandom_range(8'hFF, 8'h80));
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [wtml_pkg::PADDR_W-1:0] addr,
			input logic [wtml_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// mostly whole words with a separator, some raw noise bytes
	task automatic send_words(input int n, input int long_pct, input int pause_at);
		int  sent;
		int  len;
		bit  paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < n) begin
			if (pause_at != 0 && !paused && sent >= pause_at) begin
				wait_drain();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 75) begin
				len = ($urandom_range(99) < long_pct) ? $urandom_range(40, 25) :
					$urandom_range(9, 1);
				for (int i = 0; i < len; i++)
					send_byte(rand_word_byte());
				send_byte(rand_separator());
				sent += len + 1;
			end else begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end
		end
		wait_drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		text_byte    = '0;
		in_idle_pct  = 29;
		out_idle_pct = 83;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings
		for (int i = 0; i < DIRECTED_LEN; i++)
			send_byte(directed_text[i]);
		wait_drain();

		reg_write(ADDR_MIN_LEN, 32'd1);
		send_words(50, 10, 30);
		reg_write(ADDR_MIN_LEN, 32'd0);
		reg_write(ADDR_WORD_LIMIT, 32'hABCD_FFFF);
		send_words(30, 10, 0);
		// minimum above capacity
		reg_write(ADDR_MIN_LEN, 32'd32);
		send_words(25, 40, 0);
		reg_write(ADDR_MIN_LEN, 32'hFFFF_FFFF);
		send_words(10, 50, 0);

		in_idle_pct  = 83;
		out_idle_pct = 29;
		reg_write(ADDR_MIN_LEN, 32'd3);
		reg_write(ADDR_WORD_LIMIT, 32'd0);
		send_words(20, 5, 0);
		// limit below the words already emitted
		reg_write(ADDR_WORD_LIMIT, 32'd5);
		send_words(15, 5, 0);
		reg_write(ADDR_MIN_LEN, 32'd2);
		reg_write(ADDR_WORD_LIMIT, 32'd40);
		send_words(40, 5, 0);

		in_idle_pct  = 0;
		out_idle_pct = 0;
		reg_write(ADDR_MIN_LEN, 32'd31);
		reg_write(ADDR_WORD_LIMIT, 32'd65535);
		send_words(20, 50, 0);
		reg_write(ADDR_MIN_LEN, 32'd4);
		send_words(20, 10, 0);

		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
